// ===== src/bgac_pkg.sv =====
package bgac_pkg;

    localparam int ADC_WIDTH = 12;
    localparam int BAR_WIDTH = 3;
    localparam int MS_WIDTH  = 10;
    localparam int SEC_WIDTH = 4;
    localparam int NUM_REGS  = 8;
    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = $clog2(NUM_REGS) + 2;
    localparam int REG_INDEX_WIDTH = $clog2(NUM_REGS);

    typedef logic [ADC_WIDTH-1:0] code_t;
    typedef logic [BAR_WIDTH-1:0] bar_t;
    typedef logic [MS_WIDTH-1:0]  ms_count_t;
    typedef logic [SEC_WIDTH-1:0] sec_count_t;
    typedef logic [REG_INDEX_WIDTH-1:0] reg_index_t;

    // timing of the alarm beeps
    localparam ms_count_t  TICKS_PER_SECOND = MS_WIDTH'(1000);
    localparam sec_count_t ALARM_SECONDS    = SEC_WIDTH'(15);

    // item kinds
    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // gauge levels
    localparam bar_t BAR_EMPTY = BAR_WIDTH'(0);
    localparam bar_t BAR_ONE   = BAR_WIDTH'(1);
    localparam bar_t BAR_TWO   = BAR_WIDTH'(2);
    localparam bar_t BAR_THREE = BAR_WIDTH'(3);
    localparam bar_t BAR_FOUR  = BAR_WIDTH'(4);
    localparam bar_t BAR_FULL  = BAR_WIDTH'(5);

    // register map
    localparam reg_index_t REG_LEVEL_80     = REG_INDEX_WIDTH'(0);
    localparam reg_index_t REG_LEVEL_60     = REG_INDEX_WIDTH'(1);
    localparam reg_index_t REG_LEVEL_40     = REG_INDEX_WIDTH'(2);
    localparam reg_index_t REG_LEVEL_20     = REG_INDEX_WIDTH'(3);
    localparam reg_index_t REG_LEVEL_10     = REG_INDEX_WIDTH'(4);
    localparam reg_index_t REG_MAINS        = REG_INDEX_WIDTH'(5);
    localparam reg_index_t REG_CHARGING     = REG_INDEX_WIDTH'(6);
    localparam reg_index_t REG_DISPLAY_MIN  = REG_INDEX_WIDTH'(7);

    // register reset values, ADC codes of the volt thresholds
    localparam code_t LEVEL_80_RESET    = ADC_WIDTH'(3295);
    localparam code_t LEVEL_60_RESET    = ADC_WIDTH'(3231);
    localparam code_t LEVEL_40_RESET    = ADC_WIDTH'(3151);
    localparam code_t LEVEL_20_RESET    = ADC_WIDTH'(3070);
    localparam code_t LEVEL_10_RESET    = ADC_WIDTH'(2974);
    localparam code_t MAINS_RESET       = ADC_WIDTH'(1862);
    localparam code_t CHARGING_RESET    = ADC_WIDTH'(63);
    localparam code_t DISPLAY_MIN_RESET = ADC_WIDTH'(2679);

endpackage

// ===== src/bgac_if.sv =====
interface bgac_in_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    bgac_pkg::code_t      battery_code;
    bgac_pkg::code_t      charge_code;
    bgac_pkg::code_t      mains_code;
    logic                 key_down;

    modport source (output valid, mode, battery_code, charge_code, mains_code, key_down,
                    input ready);
    modport sink   (input valid, mode, battery_code, charge_code, mains_code, key_down,
                    output ready);
endinterface

interface bgac_out_if;
    logic                 valid;
    logic                 ready;
    bgac_pkg::bar_t       bar_segments;
    logic                 mains_lamp;
    logic                 charging_lamp;
    logic                 full_lamp;
    logic                 alarm_active;
    logic                 beep_request;

    modport source (output valid, bar_segments, mains_lamp, charging_lamp, full_lamp,
                    alarm_active, beep_request, input ready);
    modport sink   (input valid, bar_segments, mains_lamp, charging_lamp, full_lamp,
                    alarm_active, beep_request, output ready);
endinterface

// ===== src/battery_gauge_alarm_controller.sv =====
// channel   | dir | handshake   | payload
// ----------+-----+-------------+-----------------------------------------------
// in_ch     | in  | valid/ready | mode, battery_code, charge_code, mains_code,
//           |     |             | key_down
// out_ch    | out | valid/ready | bar_segments, mains_lamp, charging_lamp,
//           |     |             | full_lamp, alarm_active, beep_request
// apb       | in  | psel/penable| register writes and reads, pready always high
//
// one item per cycle while out_ch is ready; each item is held in the input register
// and is then evaluated into the state and result registers.
// the result registers hold the gauge state, so a stalled result blocks the input
// register; an empty input register still takes one item while the result waits.
// rst_n clears all state and loads the threshold reset codes, no clearing pass.
module battery_gauge_alarm_controller (
    input  logic                                    clk,
    input  logic                                    rst_n,
    bgac_in_if.sink                                 in_ch,
    bgac_out_if.source                              out_ch,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [bgac_pkg::APB_ADDR_WIDTH-1:0]     paddr,
    input  logic [bgac_pkg::APB_DATA_WIDTH-1:0]     pwdata,
    output logic [bgac_pkg::APB_DATA_WIDTH-1:0]     prdata,
    output logic                                    pready
);
    import bgac_pkg::*;

    // threshold registers
    code_t level_80_reg, level_60_reg, level_40_reg, level_20_reg, level_10_reg;
    code_t mains_present_reg, charging_code_reg, display_min_reg;
    reg_index_t reg_index;
    logic cfg_write;
    code_t wdata;

    // input stage
    logic  s1_valid_reg, s1_valid_next;
    logic  s1_mode_reg;
    code_t s1_battery_reg, s1_charge_reg, s1_mains_reg;
    logic  s1_key_reg;
    logic  in_fire, s1_adv;

    // state, doubling as the result register
    logic       out_valid_reg, out_valid_next;
    logic       alarm_on_reg, alarm_on_next;
    logic       unlocked_reg, unlocked_next;
    ms_count_t  ms_reg, ms_next, ms_inc;
    sec_count_t sec_reg, sec_next, sec_inc;
    logic       beep_pending_reg, beep_pending_next;
    logic       charging_lamp_reg, charging_lamp_next;
    logic       full_lamp_reg, full_lamp_next;
    logic       mains_lamp_reg, mains_lamp_next;
    bar_t       bar_reg, bar_next;
    logic       beep_req_reg, beep_req_next;
    logic       mains_ok;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_WIDTH-1:2];
    assign cfg_write = psel & penable & pwrite & pready;
    assign wdata     = pwdata[ADC_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_80_reg      <= LEVEL_80_RESET;
            level_60_reg      <= LEVEL_60_RESET;
            level_40_reg      <= LEVEL_40_RESET;
            level_20_reg      <= LEVEL_20_RESET;
            level_10_reg      <= LEVEL_10_RESET;
            mains_present_reg <= MAINS_RESET;
            charging_code_reg <= CHARGING_RESET;
            display_min_reg   <= DISPLAY_MIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_LEVEL_80:    level_80_reg      <= wdata;
                REG_LEVEL_60:    level_60_reg      <= wdata;
                REG_LEVEL_40:    level_40_reg      <= wdata;
                REG_LEVEL_20:    level_20_reg      <= wdata;
                REG_LEVEL_10:    level_10_reg      <= wdata;
                REG_MAINS:       mains_present_reg <= wdata;
                REG_CHARGING:    charging_code_reg <= wdata;
                REG_DISPLAY_MIN: display_min_reg   <= wdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_LEVEL_80:    prdata[ADC_WIDTH-1:0] = level_80_reg;
            REG_LEVEL_60:    prdata[ADC_WIDTH-1:0] = level_60_reg;
            REG_LEVEL_40:    prdata[ADC_WIDTH-1:0] = level_40_reg;
            REG_LEVEL_20:    prdata[ADC_WIDTH-1:0] = level_20_reg;
            REG_LEVEL_10:    prdata[ADC_WIDTH-1:0] = level_10_reg;
            REG_MAINS:       prdata[ADC_WIDTH-1:0] = mains_present_reg;
            REG_CHARGING:    prdata[ADC_WIDTH-1:0] = charging_code_reg;
            REG_DISPLAY_MIN: prdata[ADC_WIDTH-1:0] = display_min_reg;
            default:         prdata = '0;
        endcase
    end

    // handshake: the input stage moves on whenever the result slot is free or taken
    assign s1_adv         = s1_valid_reg & (~out_valid_reg | out_ch.ready);
    assign in_ch.ready    = ~s1_valid_reg | s1_adv;
    assign in_fire        = in_ch.valid & in_ch.ready;
    assign s1_valid_next  = in_fire | (s1_valid_reg & ~s1_adv);
    assign out_valid_next = s1_adv | (out_valid_reg & ~out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg    <= in_ch.mode;
            s1_battery_reg <= in_ch.battery_code;
            s1_charge_reg  <= in_ch.charge_code;
            s1_mains_reg   <= in_ch.mains_code;
            s1_key_reg     <= in_ch.key_down;
        end
    end

    assign mains_ok = s1_mains_reg >= mains_present_reg;
    assign ms_inc   = ms_reg + MS_WIDTH'(1);
    assign sec_inc  = sec_reg + SEC_WIDTH'(1);

    always_comb
    begin
        alarm_on_next      = alarm_on_reg;
        unlocked_next      = unlocked_reg;
        ms_next            = ms_reg;
        sec_next           = sec_reg;
        beep_pending_next  = beep_pending_reg;
        charging_lamp_next = charging_lamp_reg;
        full_lamp_next     = full_lamp_reg;
        mains_lamp_next    = mains_lamp_reg;
        bar_next           = bar_reg;
        beep_req_next      = 1'b0;

        if (s1_mode_reg == MODE_SCAN)
        begin
            if (mains_ok)
            begin
                mains_lamp_next = 1'b1;
                // with mains present, charge lamps freeze while the pack is too low to judge
                if (s1_battery_reg >= display_min_reg)
                begin
                    charging_lamp_next = s1_charge_reg >= charging_code_reg;
                    full_lamp_next     = ~charging_lamp_next;
                end
            end
            else
            begin
                mains_lamp_next    = 1'b0;
                charging_lamp_next = 1'b0;
                full_lamp_next     = 1'b0;
            end

            if (s1_key_reg)
            begin
                unlocked_next = 1'b1;
                alarm_on_next = 1'b0;
            end

            // fixed priority, highest level first
            if (s1_battery_reg >= level_80_reg)
                bar_next = BAR_FULL;
            else if (s1_battery_reg >= level_60_reg)
                bar_next = BAR_FOUR;
            else if (s1_battery_reg >= level_40_reg)
                bar_next = BAR_THREE;
            else if (s1_battery_reg >= level_20_reg)
                bar_next = BAR_TWO;
            else if (s1_battery_reg >= level_10_reg)
                bar_next = BAR_ONE;
            else
                bar_next = BAR_EMPTY;

            case (bar_next)
                BAR_FULL:
                begin
                    unlocked_next = 1'b0;
                    alarm_on_next = 1'b0;
                end
                BAR_FOUR, BAR_THREE, BAR_TWO:
                    alarm_on_next = 1'b0;
                BAR_EMPTY:
                begin
                    if (!mains_ok && !unlocked_next)
                        alarm_on_next = 1'b1;
                end
                default:
                    ;
            endcase

            if (!alarm_on_next)
            begin
                ms_next  = '0;
                sec_next = '0;
            end

            beep_req_next     = beep_pending_reg;
            beep_pending_next = 1'b0;
        end
        else if (alarm_on_reg)
        begin
            ms_next = ms_inc;
            if (ms_inc >= TICKS_PER_SECOND)
            begin
                ms_next  = '0;
                sec_next = sec_inc;
                if (sec_inc >= ALARM_SECONDS)
                begin
                    sec_next          = '0;
                    beep_pending_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_on_reg      <= 1'b0;
            unlocked_reg      <= 1'b0;
            ms_reg            <= '0;
            sec_reg           <= '0;
            beep_pending_reg  <= 1'b0;
            charging_lamp_reg <= 1'b0;
            full_lamp_reg     <= 1'b0;
            mains_lamp_reg    <= 1'b0;
            bar_reg           <= '0;
            beep_req_reg      <= 1'b0;
        end
        else if (s1_adv)
        begin
            alarm_on_reg      <= alarm_on_next;
            unlocked_reg      <= unlocked_next;
            ms_reg            <= ms_next;
            sec_reg           <= sec_next;
            beep_pending_reg  <= beep_pending_next;
            charging_lamp_reg <= charging_lamp_next;
            full_lamp_reg     <= full_lamp_next;
            mains_lamp_reg    <= mains_lamp_next;
            bar_reg           <= bar_next;
            beep_req_reg      <= beep_req_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.bar_segments  = bar_reg;
    assign out_ch.mains_lamp    = mains_lamp_reg;
    assign out_ch.charging_lamp = charging_lamp_reg;
    assign out_ch.full_lamp     = full_lamp_reg;
    assign out_ch.alarm_active  = alarm_on_reg;
    assign out_ch.beep_request  = beep_req_reg;

endmodule

// ===== src/bgac_checker.sv =====
module bgac_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [2:0]            bar_segments,
    input logic                  mains_lamp,
    input logic                  charging_lamp,
    input logic                  full_lamp,
    input logic                  alarm_active,
    input logic                  beep_request
);
    import bgac_pkg::*;

    // a stalled transfer keeps its result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bar_segments)
            && $stable(mains_lamp) && $stable(charging_lamp) && $stable(full_lamp)
            && $stable(alarm_active) && $stable(beep_request))
        else $error("stalled result changed");

    // with no result waiting the input side is always open
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bar_segments <= BAR_FULL)
        else $error("gauge out of range");

    // charge lamps only light with mains present, and never together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (charging_lamp || full_lamp) |-> mains_lamp
            && !(charging_lamp && full_lamp))
        else $error("charge lamps inconsistent");

endmodule

bind battery_gauge_alarm_controller bgac_checker u_bgac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .bar_segments  (out_ch.bar_segments),
    .mains_lamp    (out_ch.mains_lamp),
    .charging_lamp (out_ch.charging_lamp),
    .full_lamp     (out_ch.full_lamp),
    .alarm_active  (out_ch.alarm_active),
    .beep_request  (out_ch.beep_request)
);
